>>> rtl/wfrt_pkg.sv
// ----------------------------------------------------------------------------
// wfrt_pkg: shared types for the fragment reassembly tracker
// Header, sweep record, write command, action codes and controller states.
// ----------------------------------------------------------------------------
package wfrt_pkg;

  // Default table depth
  localparam int unsigned CONTEXTS_DEF = 16;

  // Widths fixed by the header and result fields
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W  = 12;
  localparam int unsigned FRAG_W = 4;
  localparam int unsigned EXP_W  = 5;
  localparam int unsigned CIDX_W = 4;

  typedef enum logic [2:0] {
    ACT_PASS   = 3'd0,
    ACT_DROP   = 3'd1,
    ACT_STORE  = 3'd2,
    ACT_APPEND = 3'd3,
    ACT_EMIT   = 3'd4,
    ACT_NOROOM = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_STORE = 2'd2,
    OP_INCR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_DONE  = 2'd2
  } state_t;

  // One accepted header, broadcast to every cell
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [FRAG_W-1:0] frag;
    logic              more;
  } hdr_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CIDX_W-1:0] hit_idx;
    logic [EXP_W-1:0]  hit_exp;
    logic [SEQ_W-1:0]  hit_seq;
    logic              free;
    logic [CIDX_W-1:0] free_idx;
  } rec_t;

  // Table update, aimed at the hit cell or the first idle cell
  typedef struct packed {
    op_t  op;
    logic use_hit;
  } cmd_t;

endpackage

>>> rtl/wfrt_in_if.sv
// ----------------------------------------------------------------------------
// wfrt_in_if: header channel
// Valid/ready channel that carries one frame header per item.
// ----------------------------------------------------------------------------
interface wfrt_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] source_address;
  logic [11:0] sequence_number;
  logic [3:0]  fragment_number;
  logic        more_fragments;

  modport source (
    output valid, source_address, sequence_number, fragment_number, more_fragments,
    input  ready
  );
  modport sink (
    input  valid, source_address, sequence_number, fragment_number, more_fragments,
    output ready
  );
endinterface

>>> rtl/wfrt_out_if.sv
// ----------------------------------------------------------------------------
// wfrt_out_if: decision channel
// Valid/ready channel that carries one reassembly decision per item.
// ----------------------------------------------------------------------------
interface wfrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [11:0] assembled_sequence;
  logic [3:0]  context_index;

  modport source (
    output valid, action, assembled_sequence, context_index,
    input  ready
  );
  modport sink (
    input  valid, action, assembled_sequence, context_index,
    output ready
  );
endinterface

>>> rtl/wfrt_cell.sv
// ----------------------------------------------------------------------------
// wfrt_cell: one reassembly context
// Holds sender, sequence and expected fragment of one context, folds its
// own match and idle state into the passing search record and applies the
// table update when it is the selected cell.
// ----------------------------------------------------------------------------
module wfrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wfrt_pkg::hdr_t hdr,
  input  wfrt_pkg::rec_t rec_in,
  output wfrt_pkg::rec_t rec_out,
  input  wfrt_pkg::cmd_t cmd,
  output logic          is_hit,
  output logic          is_free
);
  import wfrt_pkg::*;

  logic [ADDR_W-1:0] addr_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [EXP_W-1:0]  exp_r;
  rec_t              rec_r, rec_nxt;
  logic              is_hit_r, is_hit_nxt;
  logic              is_free_r, is_free_nxt;
  logic              active;
  logic              match;
  logic              sel;

  assign active = (exp_r != '0);
  assign match  = active && (addr_r == hdr.addr);

  // Fold this context into the search record
  always_comb begin
    rec_nxt     = rec_in;
    is_hit_nxt  = is_hit_r;
    is_free_nxt = is_free_r;
    if (rec_in.valid) begin
      is_hit_nxt  = match && !rec_in.hit;
      is_free_nxt = !active && !rec_in.free;
      if (is_hit_nxt) begin
        rec_nxt.hit     = 1'b1;
        rec_nxt.hit_idx = CIDX_W'(IDX);
        rec_nxt.hit_exp = exp_r;
        rec_nxt.hit_seq = seq_r;
      end
      if (is_free_nxt) begin
        rec_nxt.free     = 1'b1;
        rec_nxt.free_idx = CIDX_W'(IDX);
      end
    end
  end

  // Hand the record on and latch the selection flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r     <= '0;
      is_hit_r  <= 1'b0;
      is_free_r <= 1'b0;
    end else begin
      rec_r     <= rec_nxt;
      is_hit_r  <= is_hit_nxt;
      is_free_r <= is_free_nxt;
    end
  end

  assign sel = cmd.use_hit ? is_hit_r : is_free_r;

  // Apply the table update when selected
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      exp_r <= '0;
    end else if (sel) begin
      unique case (cmd.op)
        OP_CLEAR: begin
          seq_r <= '0;
          exp_r <= '0;
        end
        OP_STORE: begin
          seq_r <= hdr.seq;
          exp_r <= EXP_W'(1);
        end
        OP_INCR: exp_r <= exp_r + EXP_W'(1);
        OP_NONE: ;
      endcase
    end
  end

  // Sender address needs no reset: read only while active
  always_ff @(posedge clk) begin
    if (sel && cmd.op == OP_STORE) begin
      addr_r <= hdr.addr;
    end
  end

  assign rec_out = rec_r;
  assign is_hit  = is_hit_r;
  assign is_free = is_free_r;

endmodule

>>> rtl/wifi_fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// wifi_fragment_reassembly_tracker: 802.11 fragment reassembly decisions
// Tracks reassembly contexts per sender and gives one action per header.
//
//   channel  dir  payload                                               
//   in_ch    in   source_address, sequence_number, fragment_number,
//                 more_fragments
//   out_ch   out  action, assembled_sequence, context_index
//
// A new item is accepted only once the last one is through: a search record
// walks the row of context cells one cell per cycle, then the decision is
// made and the selected cell is updated.
// Reset idles every context at once; no clearing pass is needed.
// A result waits in the output register; the next item is accepted and
// searched meanwhile, and its decision holds until the output is free.
// ----------------------------------------------------------------------------
module wifi_fragment_reassembly_tracker #(
  parameter int unsigned CONTEXTS = wfrt_pkg::CONTEXTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wfrt_in_if.sink           in_ch,
  wfrt_out_if.source        out_ch
);
  import wfrt_pkg::*;

  state_t           state_r, state_nxt;
  hdr_t             hdr_r;
  logic             launch_r;
  rec_t             tail_r;
  rec_t             launch_rec;
  rec_t             rec [CONTEXTS];
  logic [CONTEXTS-1:0] hit_vec;
  logic [CONTEXTS-1:0] free_vec;
  cmd_t             cmd;
  logic             in_fire;
  logic             emit;
  logic             out_valid_r;
  action_t          act_r, act_nxt;
  logic [SEQ_W-1:0] aseq_r, aseq_nxt;
  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  cmd_t             dec_cmd;
  logic             frag0;
  logic             unrelated;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Capture the header and launch the search
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_r.addr <= in_ch.source_address;
      hdr_r.seq  <= in_ch.sequence_number;
      hdr_r.frag <= in_ch.fragment_number;
      hdr_r.more <= in_ch.more_fragments;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= in_fire;
    end
  end

  always_comb begin
    launch_rec       = '0;
    launch_rec.valid = launch_r;
  end

  // Row of context cells
  for (genvar k = 0; k < CONTEXTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      wfrt_cell #(.IDX(k)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr_r),
        .rec_in  (launch_rec),
        .rec_out (rec[k]),
        .cmd     (cmd),
        .is_hit  (hit_vec[k]),
        .is_free (free_vec[k])
      );
    end else begin : g_body
      wfrt_cell #(.IDX(k)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr_r),
        .rec_in  (rec[k-1]),
        .rec_out (rec[k]),
        .cmd     (cmd),
        .is_hit  (hit_vec[k]),
        .is_free (free_vec[k])
      );
    end
  end

  // Hold the finished search record
  always_ff @(posedge clk) begin
    if (state_r == S_SWEEP && rec[CONTEXTS-1].valid) begin
      tail_r <= rec[CONTEXTS-1];
    end
  end

  // Decide the action from the finished search
  assign frag0     = (hdr_r.frag == '0);
  assign unrelated = !tail_r.hit
                  || (tail_r.hit_exp != {1'b0, hdr_r.frag})
                  || ((tail_r.hit_seq != '0) && (tail_r.hit_seq != hdr_r.seq));

  always_comb begin
    act_nxt         = ACT_PASS;
    aseq_nxt        = '0;
    cidx_nxt        = '0;
    dec_cmd.op      = OP_NONE;
    dec_cmd.use_hit = 1'b1;
    priority if (!hdr_r.more && frag0) begin
      act_nxt    = ACT_PASS;
      dec_cmd.op = tail_r.hit ? OP_CLEAR : OP_NONE;
    end else if (!frag0 && unrelated) begin
      act_nxt    = ACT_DROP;
      dec_cmd.op = tail_r.hit ? OP_CLEAR : OP_NONE;
    end else if (frag0) begin
      priority if (tail_r.hit) begin
        act_nxt    = ACT_STORE;
        cidx_nxt   = tail_r.hit_idx;
        dec_cmd.op = OP_STORE;
      end else if (tail_r.free) begin
        act_nxt         = ACT_STORE;
        cidx_nxt        = tail_r.free_idx;
        dec_cmd.op      = OP_STORE;
        dec_cmd.use_hit = 1'b0;
      end else begin
        act_nxt = ACT_NOROOM;
      end
    end else if (hdr_r.more) begin
      act_nxt    = ACT_APPEND;
      cidx_nxt   = tail_r.hit_idx;
      dec_cmd.op = OP_INCR;
    end else begin
      act_nxt    = ACT_EMIT;
      aseq_nxt   = tail_r.hit_seq;
      cidx_nxt   = tail_r.hit_idx;
      dec_cmd.op = OP_CLEAR;
    end
  end

  assign emit = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    cmd = dec_cmd;
    if (!emit) begin
      cmd.op = OP_NONE;
    end
  end

  // Controller state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through search and decision
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_SWEEP;
      S_SWEEP: if (rec[CONTEXTS-1].valid) state_nxt = S_DONE;
      S_DONE:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      act_r  <= act_nxt;
      aseq_r <= aseq_nxt;
      cidx_r <= cidx_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.action             = act_r;
  assign out_ch.assembled_sequence = aseq_r;
  assign out_ch.context_index      = cidx_r;

  // Checks; flags are mixed old and new while a search walks the row
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SWEEP) |-> $onehot0(hit_vec))
    else $error("more than one cell flagged as hit");
  a_one_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SWEEP) |-> $onehot0(free_vec))
    else $error("more than one cell flagged as free");
  a_sweep_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_SWEEP)
    else $error("accepted item did not start a search");
  a_update_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |-> (state_r == S_DONE) && emit)
    else $error("table update outside the decision step");

endmodule
